// ===== sv/hsv_pkg.sv =====
// Shared constants, types and helpers for the HSV to RGB converter.
package hsv_pkg;

  // Fixed-point format of saturation and value (1.0 == ONE)
  localparam int FRACTION_BITS = 8;
  localparam int UNIT_W        = FRACTION_BITS + 1;      // clamped 0..ONE
  localparam logic [17:0] ONE_EXT = 18'(1) << FRACTION_BITS;

  // 60*ONE minus a product, always below 64*ONE
  localparam int AQ_W = FRACTION_BITS + 6;
  localparam logic [AQ_W-1:0] SIXTY_ONE = AQ_W'(60) << FRACTION_BITS;

  // Channel products and scaled intermediates
  localparam int MQ_W = UNIT_W + AQ_W;                   // val * (60*ONE - s*r)
  localparam int MP_W = 2 * UNIT_W;                      // val * (ONE - s)
  localparam int Y_W  = 14;                              // floor(255*x/ONE^2) <= 15300

  // Hue reduction: offset is a multiple of 360 that makes any 16-bit hue positive
  localparam int HUE_W = 17;
  localparam logic [HUE_W-1:0] HUE_OFFSET = HUE_W'(33120);
  localparam int HMID_W = 13;                            // remainder below 16*360

  // Reciprocal of 60 in 16 fraction bits, rounded down
  localparam int RECIP_W = 11;
  localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(1092);
  localparam int RECIP_SHIFT = 16;

  // Hue sector, one per 60 degrees
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // Hue stage result
  typedef struct packed {
    sector_t           sector;
    logic [5:0]        rem;
    logic [UNIT_W-1:0] sat;
    logic [UNIT_W-1:0] val;
  } hue_out_t;

  // Channel math result, q and t still carry an estimated quotient by 60
  typedef struct packed {
    sector_t        sector;
    logic [7:0]     cv;
    logic [7:0]     cp;
    logic [Y_W-1:0] yq;
    logic [Y_W-1:0] yt;
    logic [7:0]     qeq;
    logic [7:0]     qet;
  } chan_out_t;

  // Clamp a signed 16-bit fixed-point number to 0..ONE
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic [15:0] x);
    logic [17:0] ext;
    logic [UNIT_W-1:0] res;
    ext = {2'b00, x};
    if (x[15]) begin
      res = '0;
    end else if (ext > ONE_EXT) begin
      res = UNIT_W'(ONE_EXT);
    end else begin
      res = UNIT_W'(ext);
    end
    return res;
  endfunction

endpackage

// ===== sv/hsv_hue_reduce.sv =====
// Hue reduction modulo 360, sector split and input clamping (three stages).
module hsv_hue_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         hue,
  input  logic [15:0]         sat,
  input  logic [15:0]         bright,
  output logic                out_valid,
  output hsv_pkg::hue_out_t   hue_o
);
  import hsv_pkg::*;

  logic [2:0]        valid_r;
  logic [HMID_W-1:0] hmid_r, hmid_nxt;
  logic [8:0]        h_r, h_nxt;
  logic [UNIT_W-1:0] sat1_r, val1_r, sat2_r, val2_r;
  hue_out_t          res_r, res_nxt;

  // Offset into positive range, then subtract 360*2^k for k = 7..4
  always_comb begin
    logic [HUE_W-1:0] u;
    u = {hue[15], hue} + HUE_OFFSET;
    for (int k = 7; k >= 4; k--) begin
      if (u >= (HUE_W'(360) << k)) begin
        u = u - (HUE_W'(360) << k);
      end
    end
    hmid_nxt = HMID_W'(u);
  end

  // Finish the remainder, k = 3..0
  always_comb begin
    logic [HMID_W-1:0] w;
    w = hmid_r;
    for (int k = 3; k >= 0; k--) begin
      if (w >= (HMID_W'(360) << k)) begin
        w = w - (HMID_W'(360) << k);
      end
    end
    h_nxt = 9'(w);
  end

  // Sector and remainder within the sector
  always_comb begin
    res_nxt.sat = sat2_r;
    res_nxt.val = val2_r;
    if (h_r >= 9'd300) begin
      res_nxt.sector = SEC_5;
      res_nxt.rem    = 6'(h_r - 9'd300);
    end else if (h_r >= 9'd240) begin
      res_nxt.sector = SEC_4;
      res_nxt.rem    = 6'(h_r - 9'd240);
    end else if (h_r >= 9'd180) begin
      res_nxt.sector = SEC_3;
      res_nxt.rem    = 6'(h_r - 9'd180);
    end else if (h_r >= 9'd120) begin
      res_nxt.sector = SEC_2;
      res_nxt.rem    = 6'(h_r - 9'd120);
    end else if (h_r >= 9'd60) begin
      res_nxt.sector = SEC_1;
      res_nxt.rem    = 6'(h_r - 9'd60);
    end else begin
      res_nxt.sector = SEC_0;
      res_nxt.rem    = 6'(h_r);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      hmid_r <= hmid_nxt;
      sat1_r <= clamp_unit(sat);
      val1_r <= clamp_unit(bright);
      h_r    <= h_nxt;
      sat2_r <= sat1_r;
      val2_r <= val1_r;
      res_r  <= res_nxt;
    end
  end

  assign out_valid = valid_r[2];
  assign hue_o     = res_r;

endmodule

// ===== sv/hsv_chan_math.sv =====
// Channel products p, q, t and v scaled to 0..255 (four stages).
module hsv_chan_math (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  hsv_pkg::hue_out_t    hue_i,
  output logic                 out_valid,
  output hsv_pkg::chan_out_t   chan_o
);
  import hsv_pkg::*;

  logic [3:0]        valid_r;
  // stage 4
  logic [AQ_W-1:0]   aq_r, at_r, aq_nxt, at_nxt;
  logic [UNIT_W-1:0] ps_r, val4_r;
  sector_t           sec4_r;
  // stage 5
  logic [MQ_W-1:0]   mq_r, mt_r;
  logic [MP_W-1:0]   mp_r;
  logic [7:0]        cv5_r, cv_nxt;
  sector_t           sec5_r;
  // stage 6
  logic [Y_W-1:0]    yq_r, yt_r, yq_nxt, yt_nxt;
  logic [7:0]        cp_r, cp_nxt, cv6_r;
  sector_t           sec6_r;
  // stage 7
  chan_out_t         res_r;
  logic [7:0]        qeq_nxt, qet_nxt;

  // s*r and s*(60-r), subtracted from 60*ONE
  always_comb begin
    logic [UNIT_W+5:0] sr;
    logic [UNIT_W+5:0] s60r;
    sr     = (UNIT_W+6)'(hue_i.sat) * (UNIT_W+6)'(hue_i.rem);
    s60r   = (UNIT_W+6)'(hue_i.sat) * (UNIT_W+6)'(6'd60 - hue_i.rem);
    aq_nxt = SIXTY_ONE - AQ_W'(sr);
    at_nxt = SIXTY_ONE - AQ_W'(s60r);
  end

  // v channel: floor(255*val/ONE)
  always_comb begin
    logic [UNIT_W+7:0] v255;
    v255   = {val4_r, 8'b0} - (UNIT_W+8)'(val4_r);
    cv_nxt = 8'(v255 >> FRACTION_BITS);
  end

  // times 255, then drop 2*FRACTION_BITS
  always_comb begin
    logic [MQ_W+7:0] q255;
    logic [MQ_W+7:0] t255;
    logic [MP_W+7:0] p255;
    q255   = {mq_r, 8'b0} - (MQ_W+8)'(mq_r);
    t255   = {mt_r, 8'b0} - (MQ_W+8)'(mt_r);
    p255   = {mp_r, 8'b0} - (MP_W+8)'(mp_r);
    yq_nxt = Y_W'(q255 >> (2 * FRACTION_BITS));
    yt_nxt = Y_W'(t255 >> (2 * FRACTION_BITS));
    cp_nxt = 8'(p255 >> (2 * FRACTION_BITS));
  end

  // Quotient by 60 estimate, low by at most one
  always_comb begin
    logic [Y_W+RECIP_W-1:0] pq;
    logic [Y_W+RECIP_W-1:0] pt;
    pq      = (Y_W+RECIP_W)'(yq_r) * (Y_W+RECIP_W)'(RECIP_60);
    pt      = (Y_W+RECIP_W)'(yt_r) * (Y_W+RECIP_W)'(RECIP_60);
    qeq_nxt = 8'(pq >> RECIP_SHIFT);
    qet_nxt = 8'(pt >> RECIP_SHIFT);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[2:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      aq_r   <= aq_nxt;
      at_r   <= at_nxt;
      ps_r   <= UNIT_W'(ONE_EXT) - hue_i.sat;
      val4_r <= hue_i.val;
      sec4_r <= hue_i.sector;

      mq_r   <= MQ_W'(val4_r) * MQ_W'(aq_r);
      mt_r   <= MQ_W'(val4_r) * MQ_W'(at_r);
      mp_r   <= MP_W'(val4_r) * MP_W'(ps_r);
      cv5_r  <= cv_nxt;
      sec5_r <= sec4_r;

      yq_r   <= yq_nxt;
      yt_r   <= yt_nxt;
      cp_r   <= cp_nxt;
      cv6_r  <= cv5_r;
      sec6_r <= sec5_r;

      res_r.sector <= sec6_r;
      res_r.cv     <= cv6_r;
      res_r.cp     <= cp_r;
      res_r.yq     <= yq_r;
      res_r.yt     <= yt_r;
      res_r.qeq    <= qeq_nxt;
      res_r.qet    <= qet_nxt;
    end
  end

  assign out_valid = valid_r[3];
  assign chan_o    = res_r;

endmodule

// ===== sv/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter, eight-stage pipeline with registered stream output.
// Throughput: one item per cycle; a stall on the output freezes all stages.
// Reset (rst_n low, synchronous) clears every valid bit; data regs are not reset.
// No configuration; every item is independent of the ones before it.
module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] hue_degrees, [31:16] saturation, [47:32] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import hsv_pkg::*;

  logic      en;
  logic      hue_valid, chan_valid;
  hue_out_t  hue_res;
  chan_out_t chan_res;
  logic      out_valid_r;
  logic [23:0] rgb_r, rgb_nxt;

  // Whole pipe moves unless the output holds an item not taken
  assign en        = ~out_valid_r | out_tready;
  assign in_tready = en;

  hsv_hue_reduce u_hue (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .hue       (in_tdata[15:0]),
    .sat       (in_tdata[31:16]),
    .bright    (in_tdata[47:32]),
    .out_valid (hue_valid),
    .hue_o     (hue_res)
  );

  hsv_chan_math u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hue_valid),
    .hue_i     (hue_res),
    .out_valid (chan_valid),
    .chan_o    (chan_res)
  );

  // Quotient correction for q and t, then channel order by sector
  always_comb begin
    logic [Y_W-1:0] remq;
    logic [Y_W-1:0] remt;
    logic [7:0]     cq;
    logic [7:0]     ct;
    logic [7:0]     cv;
    logic [7:0]     cp;
    remq = chan_res.yq - Y_W'(chan_res.qeq) * Y_W'(60);
    remt = chan_res.yt - Y_W'(chan_res.qet) * Y_W'(60);
    cq   = (remq >= Y_W'(60)) ? chan_res.qeq + 8'd1 : chan_res.qeq;
    ct   = (remt >= Y_W'(60)) ? chan_res.qet + 8'd1 : chan_res.qet;
    cv   = chan_res.cv;
    cp   = chan_res.cp;
    case (chan_res.sector)
      SEC_1:   rgb_nxt = {cp, cv, cq};
      SEC_2:   rgb_nxt = {ct, cv, cp};
      SEC_3:   rgb_nxt = {cv, cq, cp};
      SEC_4:   rgb_nxt = {cv, cp, ct};
      SEC_5:   rgb_nxt = {cq, cp, cv};
      default: rgb_nxt = {cp, ct, cv};
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rgb_r;

endmodule

// ===== sv/hsv_checker.sv =====
// Port-level checks for the HSV to RGB converter, bound to the top level.
module hsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // Input side is ready exactly when the output stage can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stage");

  // Empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

endmodule

bind hsv_to_rgb_converter_core hsv_checker u_hsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_hsv_to_rgb_converter_core.sv =====
// Self-checking testbench for the HSV to RGB converter core.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_core;
  import hsv_pkg::*;

  // One input pixel and one RGB result
  typedef struct packed {
    logic signed [15:0] hue;
    logic signed [15:0] sat;
    logic signed [15:0] val;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Directed row: pixel, plus a hand-typed result where it is obvious
  typedef struct {
    hsv_t px;
    bit   typed;
    rgb_t want;
  } stim_row_t;

  localparam int N_DIRECTED     = 25;
  localparam int N_PHASES       = 5;
  localparam int RANDOM_PER_PHASE = 90;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 16;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] hue, [31:16] saturation, [47:32] brightness
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] red, [15:8] green, [23:16] blue

  rgb_t rgb_in_flight [$];
  int   mismatch_count  = 0;
  int   pixels_sent     = 0;
  int   results_checked = 0;
  int   send_idle_pct   = 0;
  int   recv_stall_pct  = 0;
  int   hold_left       = 0;

  // Flow-control phases: sender idle and receiver stall, in percent
  int send_idle_of  [N_PHASES] = '{0, 66, 0, 30, 0};
  int recv_stall_of [N_PHASES] = '{0, 0, 66, 30, 0};

  // Primaries, wrap-around, clamps and field extremes
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{16'sd0,      16'sd256,    16'sd256},    1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'sd120,    16'sd256,    16'sd256},    1'b1, '{8'd0,   8'd255, 8'd0}},
    '{'{16'sd240,    16'sd256,    16'sd256},    1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{-16'sd120,   16'sd256,    16'sd256},    1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{16'sd60,     16'sd256,    16'sd256},    1'b1, '{8'd255, 8'd255, 8'd0}},
    '{'{16'sd180,    16'sd256,    16'sd256},    1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{16'sd300,    16'sd256,    16'sd256},    1'b1, '{8'd255, 8'd0,   8'd255}},
    '{'{16'sd77,     16'sd0,      16'sd256},    1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'sd200,    16'sd256,    16'sd0},      1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'sd200,    16'sd256,    -16'sd32768}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'sd360,    16'sd32767,  16'sd32767},  1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{-16'sd360,   16'sd256,    16'sd256},    1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'sd123,    16'sd1000,   -16'sd5},     1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'sd32767,  16'sd32767,  16'sd32767},  1'b0, '0},
    '{'{16'sd30,     16'sd256,    16'sd256},    1'b0, '0},
    '{'{16'sd90,     16'sd200,    16'sd230},    1'b0, '0},
    '{'{16'sd150,    16'sd128,    16'sd256},    1'b0, '0},
    '{'{16'sd210,    16'sd255,    16'sd255},    1'b0, '0},
    '{'{16'sd270,    16'sd257,    16'sd256},    1'b0, '0},
    '{'{16'sd330,    16'sd256,    16'sd257},    1'b0, '0},
    '{'{16'sd359,    16'sd1,      16'sd256},    1'b0, '0},
    '{'{-16'sd1,     16'sd256,    16'sd256},    1'b0, '0},
    '{'{16'sd59,     16'sd256,    16'sd256},    1'b0, '0},
    '{'{16'sd45,     -16'sd1,     16'sd128},    1'b0, '0}
  };

  hsv_to_rgb_converter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Clamp a fixed-point level to 0..one
  function automatic longint level_clamp(input longint x, input longint one);
    if (x < 0) return 0;
    if (x > one) return one;
    return x;
  endfunction

  // floor(255 * num / den) as an 8-bit channel
  function automatic logic [7:0] channel_of(input longint num, input longint den);
    return 8'((num * 255) / den);
  endfunction

  // Exact integer HSV to RGB conversion
  function automatic rgb_t expected_rgb_of(input hsv_t px);
    longint  one, den, h, s, v, rem;
    logic [7:0] cv, cp, cq, ct;
    sector_t sec;
    rgb_t    c;
    one = longint'(1) << FRACTION_BITS;
    h   = longint'(px.hue) % 360;
    if (h < 0) h += 360;
    s   = level_clamp(longint'(px.sat), one);
    v   = level_clamp(longint'(px.val), one);
    sec = sector_t'(3'(h / 60));
    rem = h % 60;
    den = 60 * one * one;
    cv  = channel_of(v * one * 60, den);
    cp  = channel_of(v * (one - s) * 60, den);
    cq  = channel_of(v * (60 * one - s * rem), den);
    ct  = channel_of(v * (60 * one - s * (60 - rem)), den);
    case (sec)
      SEC_1:   c = '{cq, cv, cp};
      SEC_2:   c = '{cp, cv, ct};
      SEC_3:   c = '{cp, cq, cv};
      SEC_4:   c = '{ct, cp, cv};
      SEC_5:   c = '{cv, cp, cq};
      default: c = '{cv, ct, cp};
    endcase
    return c;
  endfunction

  // Mostly in-range colors around the wrap and clamp points, some raw 16-bit noise
  function automatic hsv_t random_pixel();
    hsv_t px;
    if ($urandom_range(99) < 75) begin
      px.hue = 16'(int'($urandom_range(0, 1079)) - 540);
      px.sat = 16'(int'($urandom_range(0, 299)) - 20);
      px.val = 16'(int'($urandom_range(0, 299)) - 20);
    end else begin
      px = 48'({$urandom, $urandom});
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one pixel, hold it until accepted, then queue its expected color
  task automatic send_pixel(input hsv_t px, input rgb_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {px.val, px.sat, px.hue};
    do @(posedge clk); while (!in_tready);
    rgb_in_flight.push_back(want);
    pixels_sent++;
  endtask

  // Output side: random stalls, or a long hold-off when one is requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expected color
  always @(posedge clk) begin : check_output
    rgb_t got;
    rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]};
      if (rgb_in_flight.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_tdata), 0);
      end else begin
        want = rgb_in_flight.pop_front();
        if (got.red !== want.red)     report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue)   report_mismatch("blue", got.blue, want.blue);
        results_checked++;
      end
    end
  end

  // Main sequence: reset, directed rows, then random pixels per phase
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = send_idle_of[ph];
      recv_stall_pct = recv_stall_of[ph];
      // last phase: block the output while the input keeps pushing
      if (ph == N_PHASES - 1) hold_left = HOLD_CYCLES;
      if (ph == 0) begin
        foreach (directed_rows[i])
          send_pixel(directed_rows[i].px, directed_rows[i].typed ?
                     directed_rows[i].want : expected_rgb_of(directed_rows[i].px));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        hsv_t px;
        px = random_pixel();
        send_pixel(px, expected_rgb_of(px));
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    // Drain, then watch for stray results
    while (rgb_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels sent over %0d flow-control phases, incl. a %0d-cycle output hold",
             pixels_sent, N_PHASES, HOLD_CYCLES);
    $display("%0d colors compared, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && rgb_in_flight.size() == 0) begin
      $display("tb_hsv_to_rgb_converter_core: clean");
    end else begin
      $display("tb_hsv_to_rgb_converter_core: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_hsv_to_rgb_converter_core: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hsv_pkg.sv
sv/hsv_hue_reduce.sv
sv/hsv_chan_math.sv
sv/hsv_to_rgb_converter_core.sv
sv/hsv_checker.sv
verif/tb_hsv_to_rgb_converter_core.sv
